/* rtl/jcsl_pkg.sv */
`default_nettype none

package jcsl_pkg;

    localparam int CFG_DATA_W = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int JOINT_W    = 5;
    localparam int STEP_W     = 17;
    localparam int SCALE_W    = 10;
    localparam int MASK_W     = 29;
    localparam int THRESH_W   = 18;
    localparam int KP_W       = 17;
    localparam int KD_W       = 10;
    localparam int BASE_KP_W  = 7;

    localparam logic [KD_W-1:0] KD_LIMP = 10'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_STEP        = 3'd0,
        CFG_LOW_BODY_SCALE  = 3'd1,
        CFG_ARM_SCALE       = 3'd2,
        CFG_ACTIVE_MASK     = 3'd3,
        CFG_HOLD_INACTIVE   = 3'd4,
        CFG_REACH_THRESHOLD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [STEP_W-1:0]   step_limit;
        logic [SCALE_W-1:0]  low_body_scale;
        logic [SCALE_W-1:0]  arm_scale;
        logic [MASK_W-1:0]   active_mask;
        logic                hold_inactive;
        logic [THRESH_W-1:0] reach_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        step_limit:      17'd983,
        low_body_scale:  10'd90,
        arm_scale:       10'd256,
        active_mask:     29'h1FFF_FFFF,
        hold_inactive:   1'b0,
        reach_threshold: 18'd6554
    };

    // What the back end does with a word.
    typedef enum logic [2:0] {
        KIND_SKIP,
        KIND_SEED,
        KIND_STEP,
        KIND_HOLD,
        KIND_LIMP
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [JOINT_W-1:0]  joint;
        logic [KP_W-1:0]     kp;
        logic [KD_W-1:0]     kd;
        logic                frame_end;
    } t_cls;

    function automatic logic [BASE_KP_W-1:0] base_kp(input logic [JOINT_W-1:0] j);
        logic [BASE_KP_W-1:0] v;
        case (j) inside
            5'd3, 5'd9:                               v = 7'd100;
            5'd0, 5'd1, 5'd2, 5'd6, 5'd7, 5'd8, 5'd12: v = 7'd60;
            default:                                  v = 7'd40;
        endcase
        return v;
    endfunction

    // Knees get double damping; gain already times 256.
    function automatic logic [KD_W-1:0] base_kd(input logic [JOINT_W-1:0] j);
        logic [KD_W-1:0] v;
        case (j) inside
            5'd3, 5'd9: v = 10'd512;
            default:    v = 10'd256;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/jcsl_in_if.sv */
`default_nettype none

interface jcsl_in_if #(
    parameter int ANGLE_BITS = 19
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [4:0]                   joint;
    logic signed [ANGLE_BITS-1:0] position;
    logic                         frame_end;

    modport source (output valid, action, joint, position, frame_end, input ready);
    modport sink   (input valid, action, joint, position, frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/jcsl_out_if.sv */
`default_nettype none

interface jcsl_out_if #(
    parameter int ANGLE_BITS = 19
);
    logic                         valid;
    logic                         ready;
    logic [4:0]                   joint_out;
    logic signed [ANGLE_BITS-1:0] command_position;
    logic [16:0]                  kp_gain;
    logic [9:0]                   kd_gain;
    logic                         held;
    logic [16:0]                  max_applied_step;
    logic [ANGLE_BITS-1:0]        peak_error;
    logic                         reached;
    logic                         frame_done;

    modport source (output valid, joint_out, command_position, kp_gain, kd_gain, held,
                    max_applied_step, peak_error, reached, frame_done, input ready);
    modport sink   (input valid, joint_out, command_position, kp_gain, kd_gain, held,
                    max_applied_step, peak_error, reached, frame_done, output ready);
endinterface

`default_nettype wire

/* rtl/jcsl_front.sv */
`default_nettype none

// Classify an incoming word and look up its gains.
module jcsl_front #(
    parameter int JOINT_COUNT     = 29,
    parameter int LOW_BODY_JOINTS = 15
) (
    input  wire  jcsl_pkg::t_cfg              i_cfg,
    input  wire                               i_action,
    input  wire  [jcsl_pkg::JOINT_W-1:0]      i_joint,
    input  wire                               i_frame_end,
    output jcsl_pkg::t_cls                    o_cls
);
    logic                                 in_range;
    logic                                 low_body;
    logic                                 active;
    logic [31:0]                          mask_x;
    logic [jcsl_pkg::SCALE_W-1:0]         scale;
    logic [jcsl_pkg::KP_W-1:0]            table_kp;
    logic [jcsl_pkg::KD_W-1:0]            table_kd;

    assign in_range = {2'b00, i_joint} < 7'(JOINT_COUNT);
    assign low_body = {2'b00, i_joint} < 7'(LOW_BODY_JOINTS);
    assign mask_x   = {3'b000, i_cfg.active_mask};
    assign active   = mask_x[i_joint];
    assign scale    = low_body ? i_cfg.low_body_scale : i_cfg.arm_scale;
    assign table_kp = jcsl_pkg::KP_W'(jcsl_pkg::base_kp(i_joint)) * jcsl_pkg::KP_W'(scale);
    assign table_kd = jcsl_pkg::base_kd(i_joint);

    always_comb begin
        o_cls.joint     = i_joint;
        o_cls.frame_end = i_frame_end;
        o_cls.kp        = '0;
        o_cls.kd        = '0;
        if (!in_range) begin
            o_cls.kind = jcsl_pkg::KIND_SKIP;
        end else if (!i_action) begin
            o_cls.kind = jcsl_pkg::KIND_SEED;
        end else if (active) begin
            o_cls.kind = jcsl_pkg::KIND_STEP;
            o_cls.kp   = table_kp;
            o_cls.kd   = table_kd;
        end else if (i_cfg.hold_inactive) begin
            o_cls.kind = jcsl_pkg::KIND_HOLD;
            o_cls.kp   = table_kp;
            o_cls.kd   = table_kd;
        end else begin
            o_cls.kind = jcsl_pkg::KIND_LIMP;
            o_cls.kd   = jcsl_pkg::KD_LIMP;
        end
    end
endmodule

`default_nettype wire

/* rtl/jcsl_queue.sv */
`default_nettype none

// Two-entry queue between front and back.
module jcsl_queue #(
    parameter int DATA_W = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

`default_nettype wire

/* rtl/jcsl_back.sv */
`default_nettype none

// Slew clamp, command store, frame peaks and output register.
module jcsl_back #(
    parameter int JOINT_COUNT = 29,
    parameter int ANGLE_BITS  = 19
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  jcsl_pkg::t_cfg          i_cfg,
    input  wire                           i_head_valid,
    input  wire  jcsl_pkg::t_cls          i_head,
    input  wire  [ANGLE_BITS-1:0]         i_head_pos,
    output logic                          o_pop,
    jcsl_out_if.source                    o_out
);
    localparam int JIW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int CW  = (ANGLE_BITS + 2 > 19) ? ANGLE_BITS + 2 : 19;
    localparam int RW  = (ANGLE_BITS > jcsl_pkg::THRESH_W) ? ANGLE_BITS : jcsl_pkg::THRESH_W;

    logic signed [ANGLE_BITS-1:0] r_last [JOINT_COUNT];
    logic [jcsl_pkg::STEP_W-1:0]  r_step_pk;
    logic [ANGLE_BITS-1:0]        r_err_pk;

    logic                         r_out_valid;
    logic [jcsl_pkg::JOINT_W-1:0] r_joint;
    logic signed [ANGLE_BITS-1:0] r_cmd;
    logic [jcsl_pkg::KP_W-1:0]    r_kp;
    logic [jcsl_pkg::KD_W-1:0]    r_kd;
    logic                         r_held;
    logic [jcsl_pkg::STEP_W-1:0]  r_step_out;
    logic [ANGLE_BITS-1:0]        r_err_out;
    logic                         r_reached;
    logic                         r_frame_done;

    logic [5:0]                   joint_x;
    logic [JIW-1:0]               idx;
    logic signed [ANGLE_BITS-1:0] last;
    logic signed [ANGLE_BITS-1:0] pos;
    logic signed [CW-1:0]         diff;
    logic signed [CW-1:0]         lim;
    logic signed [CW-1:0]         delta;
    logic signed [CW-1:0]         cmd_w;
    logic [CW-1:0]                abs_diff;
    logic [CW-1:0]                abs_delta;
    logic signed [ANGLE_BITS-1:0] step_cmd;
    logic signed [ANGLE_BITS-1:0] cmd;
    logic                         is_step;
    logic                         fire;
    logic [jcsl_pkg::STEP_W-1:0]  n_step_pk;
    logic [ANGLE_BITS-1:0]        n_err_pk;
    logic                         reached;

    assign joint_x = {1'b0, i_head.joint};
    assign idx     = joint_x[JIW-1:0];
    assign last    = r_last[idx];
    assign pos     = $signed(i_head_pos);
    assign is_step = i_head.kind == jcsl_pkg::KIND_STEP;
    assign fire    = i_head_valid && (!r_out_valid || o_out.ready);
    assign o_pop   = fire;

    // Clamp the move toward target; the new command lies between last and target.
    always_comb begin
        diff = CW'(pos) - CW'(last);
        lim  = $signed(CW'(i_cfg.step_limit));
        if (diff > lim) begin
            delta = lim;
        end else if (diff < -lim) begin
            delta = -lim;
        end else begin
            delta = diff;
        end
        cmd_w     = CW'(last) + delta;
        step_cmd  = cmd_w[ANGLE_BITS-1:0];
        abs_diff  = diff[CW-1] ? $unsigned(-diff) : $unsigned(diff);
        abs_delta = delta[CW-1] ? $unsigned(-delta) : $unsigned(delta);
    end

    always_comb begin
        case (i_head.kind)
            jcsl_pkg::KIND_SEED: cmd = pos;
            jcsl_pkg::KIND_STEP: cmd = step_cmd;
            jcsl_pkg::KIND_HOLD,
            jcsl_pkg::KIND_LIMP: cmd = last;
            default:             cmd = '0;
        endcase
    end

    always_comb begin
        n_step_pk = r_step_pk;
        n_err_pk  = r_err_pk;
        if (is_step) begin
            if (abs_delta[jcsl_pkg::STEP_W-1:0] > r_step_pk) begin
                n_step_pk = abs_delta[jcsl_pkg::STEP_W-1:0];
            end
            if (abs_diff[ANGLE_BITS-1:0] > r_err_pk) begin
                n_err_pk = abs_diff[ANGLE_BITS-1:0];
            end
        end
        reached = i_head.frame_end && (RW'(n_err_pk) <= RW'(i_cfg.reach_threshold));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_last[k] <= '0;
            end
            r_step_pk <= '0;
            r_err_pk  <= '0;
        end else if (fire) begin
            if (i_head.kind == jcsl_pkg::KIND_SEED || is_step) begin
                r_last[idx] <= cmd;
            end
            // Clear peaks after the frame's last word.
            r_step_pk <= i_head.frame_end ? '0 : n_step_pk;
            r_err_pk  <= i_head.frame_end ? '0 : n_err_pk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_joint      <= i_head.joint;
            r_cmd        <= cmd;
            r_kp         <= i_head.kp;
            r_kd         <= i_head.kd;
            r_held       <= i_head.kind == jcsl_pkg::KIND_HOLD;
            r_step_out   <= n_step_pk;
            r_err_out    <= n_err_pk;
            r_reached    <= reached;
            r_frame_done <= i_head.frame_end;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.joint_out        = r_joint;
    assign o_out.command_position = r_cmd;
    assign o_out.kp_gain          = r_kp;
    assign o_out.kd_gain          = r_kd;
    assign o_out.held             = r_held;
    assign o_out.max_applied_step = r_step_out;
    assign o_out.peak_error       = r_err_out;
    assign o_out.reached          = r_reached;
    assign o_out.frame_done       = r_frame_done;
endmodule

`default_nettype wire

/* rtl/joint_command_slew_limiter_core.sv */
// Joint command slew limiter.
// Input channel i_in carries one word per joint: action (0 seed the joint's
// last command from a measured position, 1 step toward a target), joint,
// position and frame_end. Output channel o_out returns one word for every
// input word: the new command, kp/kd gains, held flag, the running peaks of
// applied step and target error within the frame, and on the frame's last
// word the reached flag and frame_done.
// Both channels use valid/ready; a word moves when both are high.
// An accepted word passes through the queue, then the output register, before it
// shows on o_out. Throughput: one word per cycle while o_out is not stalled, set by
// the single back-end stage that reads, clamps and writes the joint's stored command.
// A two-entry queue decouples the front (classify, gain lookup) from the
// back (clamp, store, peaks); when o_out stalls the output register holds,
// the queue fills and i_in.ready drops once two words wait.
// The user must write configuration through i_cfg_we/i_cfg_index/i_cfg_data only
// while no word is in flight (the block does not enforce this); unknown indexes are ignored.
// Reset (i_rst_n low, synchronous) restores register defaults, clears all
// stored commands and both peaks, and empties the pipeline.
`default_nettype none

module joint_command_slew_limiter_core #(
    parameter int JOINT_COUNT     = 29,
    parameter int LOW_BODY_JOINTS = 15,
    parameter int ANGLE_BITS      = 19
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [jcsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [jcsl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    jcsl_in_if.sink                            i_in,
    jcsl_out_if.source                         o_out
);
    localparam int CLS_W = $bits(jcsl_pkg::t_cls);
    localparam int QW    = CLS_W + ANGLE_BITS;

    jcsl_pkg::t_cfg   r_cfg;
    jcsl_pkg::t_cls   front_cls;
    jcsl_pkg::t_cls   head_cls;
    logic [QW-1:0]    q_head;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;

    // Register file: apply a write at its index, drop unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= jcsl_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (jcsl_pkg::t_cfg_idx'(i_cfg_index))
                jcsl_pkg::CFG_MAX_STEP:
                    r_cfg.step_limit <= i_cfg_data[jcsl_pkg::STEP_W-1:0];
                jcsl_pkg::CFG_LOW_BODY_SCALE:
                    r_cfg.low_body_scale <= i_cfg_data[jcsl_pkg::SCALE_W-1:0];
                jcsl_pkg::CFG_ARM_SCALE:
                    r_cfg.arm_scale <= i_cfg_data[jcsl_pkg::SCALE_W-1:0];
                jcsl_pkg::CFG_ACTIVE_MASK:
                    r_cfg.active_mask <= i_cfg_data[jcsl_pkg::MASK_W-1:0];
                jcsl_pkg::CFG_HOLD_INACTIVE:
                    r_cfg.hold_inactive <= i_cfg_data[0];
                jcsl_pkg::CFG_REACH_THRESHOLD:
                    r_cfg.reach_threshold <= i_cfg_data[jcsl_pkg::THRESH_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Front: accept whenever the queue has room.
    assign i_in.ready = !q_full;
    assign push       = i_in.valid && !q_full;

    jcsl_front #(
        .JOINT_COUNT     (JOINT_COUNT),
        .LOW_BODY_JOINTS (LOW_BODY_JOINTS)
    ) u_front (
        .i_cfg       (r_cfg),
        .i_action    (i_in.action),
        .i_joint     (i_in.joint),
        .i_frame_end (i_in.frame_end),
        .o_cls       (front_cls)
    );

    jcsl_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cls, i_in.position}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_cls = jcsl_pkg::t_cls'(q_head[QW-1:ANGLE_BITS]);

    // Back: one queued word per cycle into the output register while o_out is not stalled.
    jcsl_back #(
        .JOINT_COUNT (JOINT_COUNT),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (!q_empty),
        .i_head       (head_cls),
        .i_head_pos   (q_head[ANGLE_BITS-1:0]),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule

`default_nettype wire

/* verif/tb_joint_command_slew_limiter_core.sv */
`timescale 1ns / 1ps

module tb_joint_command_slew_limiter_core;

    localparam int ANGLE_W        = 19;
    localparam int JOINTS         = 29;
    localparam int LOW_BODY       = 15;
    localparam int POS_MIN        = -262144;
    localparam int POS_MAX        = 262143;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_WORDS    = 112;
    localparam int PRESSURE_WORDS = 40;
    localparam int MAX_PRINTED    = 40;

    // Register indexes the block must ignore.
    localparam logic [jcsl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [jcsl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic {
        ACT_SEED = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef struct packed {
        t_action                      action;
        logic [jcsl_pkg::JOINT_W-1:0] joint;
        logic signed [ANGLE_W-1:0]    position;
        logic                         frame_end;
    } t_cmd_word;

    typedef struct packed {
        logic [jcsl_pkg::JOINT_W-1:0] joint_out;
        logic signed [ANGLE_W-1:0]    command_position;
        logic [jcsl_pkg::KP_W-1:0]    kp_gain;
        logic [jcsl_pkg::KD_W-1:0]    kd_gain;
        logic                         held;
        logic [jcsl_pkg::STEP_W-1:0]  max_applied_step;
        logic [ANGLE_W-1:0]           peak_error;
        logic                         reached;
        logic                         frame_done;
    } t_cmd_result;

    // Shadow of the limiter: registers, per-joint last command, frame peaks,
    // and the queue of commands the block still owes us.
    class slew_scoreboard;
        logic [jcsl_pkg::STEP_W-1:0]   step_limit;
        logic [jcsl_pkg::SCALE_W-1:0]  low_body_scale;
        logic [jcsl_pkg::SCALE_W-1:0]  arm_scale;
        logic [jcsl_pkg::MASK_W-1:0]   active_mask;
        logic                          hold_inactive;
        logic [jcsl_pkg::THRESH_W-1:0] reach_threshold;
        logic signed [ANGLE_W-1:0]     last_cmd [JOINTS];
        logic [jcsl_pkg::STEP_W-1:0]   step_peak;
        logic [ANGLE_W-1:0]            error_peak;
        t_cmd_result                   expected_cmds [$];
        int                            errors;

        function new();
            step_limit      = 17'd983;
            low_body_scale  = 10'd90;
            arm_scale       = 10'd256;
            active_mask     = '1;
            hold_inactive   = 1'b0;
            reach_threshold = 18'd6554;
            foreach (last_cmd[j]) last_cmd[j] = '0;
            step_peak  = '0;
            error_peak = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [jcsl_pkg::CFG_IDX_W-1:0] idx,
                                logic [jcsl_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                jcsl_pkg::CFG_MAX_STEP:
                    step_limit      = data[jcsl_pkg::STEP_W-1:0];
                jcsl_pkg::CFG_LOW_BODY_SCALE:
                    low_body_scale  = data[jcsl_pkg::SCALE_W-1:0];
                jcsl_pkg::CFG_ARM_SCALE:
                    arm_scale       = data[jcsl_pkg::SCALE_W-1:0];
                jcsl_pkg::CFG_ACTIVE_MASK:
                    active_mask     = data[jcsl_pkg::MASK_W-1:0];
                jcsl_pkg::CFG_HOLD_INACTIVE:
                    hold_inactive   = data[0];
                jcsl_pkg::CFG_REACH_THRESHOLD:
                    reach_threshold = data[jcsl_pkg::THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function void joint_gains(logic [jcsl_pkg::JOINT_W-1:0] j,
                                  output logic [jcsl_pkg::KP_W-1:0] kp,
                                  output logic [jcsl_pkg::KD_W-1:0] kd);
            int unsigned base;
            int unsigned scale;
            case (j)
                5'd3, 5'd9:                                base = 100;
                5'd0, 5'd1, 5'd2, 5'd6, 5'd7, 5'd8, 5'd12: base = 60;
                default:                                   base = 40;
            endcase
            scale = (j < LOW_BODY) ? low_body_scale : arm_scale;
            kp = jcsl_pkg::KP_W'(base * scale);
            kd = (j == 5'd3 || j == 5'd9) ? jcsl_pkg::KD_W'(2 * 256) : jcsl_pkg::KD_W'(256);
        endfunction

        function void predict_command(t_cmd_word w);
            t_cmd_result r;
            int last;
            int pos;
            int delta;
            int lim;
            int unsigned applied;
            int unsigned err;
            r = '0;
            r.joint_out  = w.joint;
            r.frame_done = w.frame_end;
            if (w.joint < JOINTS) begin
                last = last_cmd[w.joint];
                pos  = $signed(w.position);
                if (w.action == ACT_SEED) begin
                    last_cmd[w.joint]  = w.position;
                    r.command_position = w.position;
                end else if (active_mask[w.joint]) begin
                    lim   = step_limit;
                    delta = pos - last;
                    if (delta > lim) delta = lim;
                    if (delta < -lim) delta = -lim;
                    last_cmd[w.joint]  = ANGLE_W'(last + delta);
                    r.command_position = ANGLE_W'(last + delta);
                    joint_gains(w.joint, r.kp_gain, r.kd_gain);
                    // Both magnitudes fit their peak widths; no saturation needed.
                    applied = unsigned'((delta < 0) ? -delta : delta);
                    err     = unsigned'((pos < last) ? last - pos : pos - last);
                    if (applied > step_peak) step_peak = jcsl_pkg::STEP_W'(applied);
                    if (err > error_peak) error_peak = ANGLE_W'(err);
                end else if (hold_inactive) begin
                    r.command_position = last_cmd[w.joint];
                    joint_gains(w.joint, r.kp_gain, r.kd_gain);
                    r.held = 1'b1;
                end else begin
                    r.command_position = last_cmd[w.joint];
                    r.kd_gain          = jcsl_pkg::KD_LIMP;
                end
            end
            if (w.frame_end) r.reached = (error_peak <= reach_threshold);
            r.max_applied_step = step_peak;
            r.peak_error       = error_peak;
            expected_cmds.insert(expected_cmds.size(), r);
            if (w.frame_end) begin
                step_peak  = '0;
                error_peak = '0;
            end
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_command(t_cmd_result got);
            t_cmd_result want;
            if (expected_cmds.size() == 0) begin
                report($sformatf("unexpected command for joint %0d", got.joint_out));
            end else begin
                want = expected_cmds.pop_front();
                cmp_field("joint_out", got.joint_out, want.joint_out);
                cmp_field("command_position", got.command_position, want.command_position);
                cmp_field("kp_gain", got.kp_gain, want.kp_gain);
                cmp_field("kd_gain", got.kd_gain, want.kd_gain);
                cmp_field("held", got.held, want.held);
                cmp_field("max_applied_step", got.max_applied_step, want.max_applied_step);
                cmp_field("peak_error", got.peak_error, want.peak_error);
                cmp_field("reached", got.reached, want.reached);
                cmp_field("frame_done", got.frame_done, want.frame_done);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                            cfg_we;
    logic [jcsl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [jcsl_pkg::CFG_DATA_W-1:0] cfg_data;

    jcsl_in_if  #(.ANGLE_BITS(ANGLE_W)) cmd_in ();
    jcsl_out_if #(.ANGLE_BITS(ANGLE_W)) cmd_out ();

    slew_scoreboard sb;

    // Idle odds in percent per cycle for each side, set by the phase sequencer.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Long receiver hold-offs asked for and served; one writer each.
    int hold_asks = 0;
    int holds_served = 0;

    t_cmd_result seen_cmd;
    t_cmd_word   seen_word;

    joint_command_slew_limiter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (cmd_in),
        .o_out       (cmd_out)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sample both channels at the edge. Check the outgoing word before noting
    // the incoming one so a same-edge pair never reorders the queue.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_out.valid && cmd_out.ready) begin
                seen_cmd = '{cmd_out.joint_out, cmd_out.command_position, cmd_out.kp_gain,
                             cmd_out.kd_gain, cmd_out.held, cmd_out.max_applied_step,
                             cmd_out.peak_error, cmd_out.reached, cmd_out.frame_done};
                sb.check_command(seen_cmd);
            end
            if (cmd_in.valid && cmd_in.ready) begin
                seen_word = '{t_action'(cmd_in.action), cmd_in.joint, cmd_in.position,
                              cmd_in.frame_end};
                sb.predict_command(seen_word);
            end
        end
    end

    // Receiver: drop ready at random, or hold it low for a long fixed stretch
    // when the sequencer asks, so the block backs up into its input.
    initial begin
        cmd_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != holds_served) begin
                holds_served++;
                cmd_out.ready <= 1'b0;
                for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge clk);
            end else begin
                cmd_out.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one word and hold it until the block takes it. Idle cycles go in
    // front of the word, never between a word and its acceptance.
    task automatic send_word(t_action act, logic [jcsl_pkg::JOINT_W-1:0] joint, int pos,
                             logic fend);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_in.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_in.valid     <= 1'b1;
        cmd_in.action    <= act;
        cmd_in.joint     <= joint;
        cmd_in.position  <= ANGLE_W'(pos);
        cmd_in.frame_end <= fend;
        do @(posedge clk); while (!cmd_in.ready);
    endtask

    // Random word: mostly steps on valid joints, aimed near the joint's last
    // command so clamped and unclamped moves both show up; some extremes,
    // some full-range noise, a few out-of-range joints.
    task automatic send_random_word();
        t_action                      act;
        logic [jcsl_pkg::JOINT_W-1:0] joint;
        int                           last;
        int                           span;
        int                           pos;
        act   = ($urandom_range(99) < 85) ? ACT_STEP : ACT_SEED;
        joint = ($urandom_range(99) < 4) ? jcsl_pkg::JOINT_W'($urandom_range(31, JOINTS))
                                         : jcsl_pkg::JOINT_W'($urandom_range(JOINTS - 1));
        last  = (joint < JOINTS) ? sb.last_cmd[joint] : 0;
        span  = ($urandom_range(1) == 1) ? 2 * int'(sb.step_limit) + 2 : 64;
        case ($urandom_range(9))
            0:       pos = POS_MIN;
            1:       pos = POS_MAX;
            2, 3:    pos = $signed(ANGLE_W'($urandom));
            default: pos = last + int'($urandom_range(2 * span)) - span;
        endcase
        if (pos < POS_MIN) pos = POS_MIN;
        if (pos > POS_MAX) pos = POS_MAX;
        send_word(act, joint, pos, $urandom_range(7) == 0);
    endtask

    task automatic write_reg(logic [jcsl_pkg::CFG_IDX_W-1:0] idx,
                             logic [jcsl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every expected command is back; every word
    // yields exactly one command, so the block is idle afterwards.
    task automatic drain();
        cmd_in.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_cmds.size() != 0);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:       begin tx_idle_pct = 20; rx_idle_pct = 58; end
            1:       begin tx_idle_pct = 58; rx_idle_pct = 20; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
    endtask

    // Program one random phase; the first and last phases pin the extremes.
    task automatic program_phase(int ph);
        if (ph == 0) begin
            write_reg(jcsl_pkg::CFG_MAX_STEP, 29'd1);
            write_reg(jcsl_pkg::CFG_LOW_BODY_SCALE, 29'd0);
            write_reg(jcsl_pkg::CFG_ARM_SCALE, 29'd0);
            write_reg(jcsl_pkg::CFG_REACH_THRESHOLD, 29'd1);
        end else if (ph == RAND_PHASES - 1) begin
            write_reg(jcsl_pkg::CFG_MAX_STEP, 29'd65536);
            write_reg(jcsl_pkg::CFG_LOW_BODY_SCALE, 29'd1023);
            write_reg(jcsl_pkg::CFG_ARM_SCALE, 29'd1023);
            write_reg(jcsl_pkg::CFG_REACH_THRESHOLD, 29'd262143);
        end else begin
            write_reg(jcsl_pkg::CFG_MAX_STEP,
                      jcsl_pkg::CFG_DATA_W'($urandom_range(4000, 1)));
            write_reg(jcsl_pkg::CFG_LOW_BODY_SCALE,
                      jcsl_pkg::CFG_DATA_W'($urandom_range(1023)));
            write_reg(jcsl_pkg::CFG_ARM_SCALE,
                      jcsl_pkg::CFG_DATA_W'($urandom_range(1023)));
            write_reg(jcsl_pkg::CFG_REACH_THRESHOLD,
                      jcsl_pkg::CFG_DATA_W'($urandom_range(20000, 1)));
        end
        write_reg(jcsl_pkg::CFG_ACTIVE_MASK,
                  (ph == RAND_PHASES - 1) ? '1 : jcsl_pkg::CFG_DATA_W'($urandom));
        write_reg(jcsl_pkg::CFG_HOLD_INACTIVE, jcsl_pkg::CFG_DATA_W'($urandom_range(1)));
        write_reg(($urandom_range(1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  jcsl_pkg::CFG_DATA_W'($urandom));
    endtask

    initial begin
        sb = new();
        cmd_in.valid     <= 1'b0;
        cmd_in.action    <= ACT_SEED;
        cmd_in.joint     <= '0;
        cmd_in.position  <= '0;
        cmd_in.frame_end <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= jcsl_pkg::CFG_MAX_STEP;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: full-scale seeds and steps, clamping both
        // ways, saturated error, both gain regions, out-of-range joints.
        set_idling(0);
        send_word(ACT_SEED, 5'd0, POS_MAX, 1'b0);
        send_word(ACT_STEP, 5'd0, POS_MIN, 1'b0);
        send_word(ACT_SEED, 5'd3, POS_MIN, 1'b0);
        send_word(ACT_STEP, 5'd3, POS_MAX, 1'b0);
        send_word(ACT_STEP, 5'd3, POS_MIN + 100, 1'b0);
        send_word(ACT_STEP, 5'd28, 500, 1'b1);
        send_word(ACT_STEP, 5'd14, 300, 1'b0);
        send_word(ACT_STEP, 5'd15, -300, 1'b0);
        send_word(ACT_STEP, 5'd29, 1234, 1'b0);
        send_word(ACT_SEED, 5'd31, -777, 1'b0);
        send_word(ACT_STEP, 5'd30, POS_MAX, 1'b1);
        drain();

        // Zero step size, limp inactive joints, zero reach threshold.
        write_reg(jcsl_pkg::CFG_MAX_STEP, 29'd0);
        write_reg(jcsl_pkg::CFG_ACTIVE_MASK, 29'h1555_5555);
        write_reg(jcsl_pkg::CFG_HOLD_INACTIVE, 29'd0);
        write_reg(jcsl_pkg::CFG_REACH_THRESHOLD, 29'd0);
        send_word(ACT_STEP, 5'd2, 1000, 1'b0);
        send_word(ACT_STEP, 5'd3, -1000, 1'b1);
        send_word(ACT_STEP, 5'd4, 0, 1'b1);
        drain();

        // Widest step field (all-ones data, masked), top scales and threshold.
        write_reg(jcsl_pkg::CFG_MAX_STEP, '1);
        write_reg(jcsl_pkg::CFG_LOW_BODY_SCALE, 29'd1023);
        write_reg(jcsl_pkg::CFG_ARM_SCALE, 29'd1023);
        write_reg(jcsl_pkg::CFG_ACTIVE_MASK, '1);
        write_reg(jcsl_pkg::CFG_REACH_THRESHOLD, 29'd262143);
        send_word(ACT_STEP, 5'd0, POS_MIN, 1'b0);
        send_word(ACT_STEP, 5'd28, POS_MAX, 1'b0);
        send_word(ACT_STEP, 5'd9, 4000, 1'b1);
        drain();

        // Every joint inactive and holding.
        write_reg(jcsl_pkg::CFG_ACTIVE_MASK, 29'd0);
        write_reg(jcsl_pkg::CFG_HOLD_INACTIVE, 29'd1);
        send_word(ACT_STEP, 5'd3, 17, 1'b0);
        send_word(ACT_STEP, 5'd20, -17, 1'b0);
        send_word(ACT_STEP, 5'd14, 5, 1'b1);
        drain();

        // Random phases: two per idling pattern, fresh settings each time.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_phase(ph);
            set_idling(ph / 2);
            if (ph == 4) begin
                // Stall the receiver and keep offering words until input backs up.
                hold_asks++;
                for (int n = 0; n < PRESSURE_WORDS; n++) send_random_word();
            end
            for (int n = 0; n < PHASE_WORDS; n++) send_random_word();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
            $display("joint_command_slew_limiter_core verification clean");
        end else begin
            $display("joint_command_slew_limiter_core verification failed");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #400000;
        $display("joint_command_slew_limiter_core verification failed");
        $finish;
    end

endmodule
